### hw/rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

   // register indexes of the control port
   localparam logic [2:0] REG_KEY_SIZE = 3'd0;
   localparam logic [2:0] REG_KEY_LAST = 3'd4;

   // number of pipeline round stages (longest key)
   localparam int NumRounds = 14;

   typedef struct packed {
      logic valid;
      logic decrypt;
   } stage_ctl_type;

   // forward S-box, entry 0 in the top byte
   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   function automatic logic [2047:0] build_inv_sbox();
      logic [2047:0] t;
      logic [7:0]    f;
      t = '0;
      for (int x = 0; x < 256; x++) begin
         f = SBOX_TABLE[{~8'(x), 3'b000} +: 8];
         t[{~f, 3'b000} +: 8] = 8'(x);
      end
      return t;
   endfunction

   localparam logic [2047:0] INV_SBOX_TABLE = build_inv_sbox();

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_TABLE[{~x, 3'b000} +: 8];
   endfunction

   // multiply by x modulo 0x11B
   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // rounds for a key size code; code 3 acts as 256 bits
   function automatic logic [3:0] rounds_of(input logic [1:0] ks);
      logic [3:0] n;
      case (ks)
         2'd0:    n = 4'd10;
         2'd1:    n = 4'd12;
         default: n = 4'd14;
      endcase
      return n;
   endfunction

   // byte i of the state sits at bits 127-8i downward
   function automatic logic [127:0] sub_bytes(input logic [127:0] s);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = sbox(s[127-8*i -: 8]);
      return o;
   endfunction

   function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = inv_sbox(s[127-8*i -: 8]);
      return o;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
      return o;
   endfunction

   function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
      return o;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         o[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         o[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         o[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         o[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      return o;
   endfunction

   // products by 9, b, d, e built from doublings
   function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0]   a   [4];
      logic [7:0]   m2  [4];
      logic [7:0]   m4  [4];
      logic [7:0]   m8  [4];
      logic [7:0]   m9  [4];
      logic [7:0]   mb  [4];
      logic [7:0]   md  [4];
      logic [7:0]   me  [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = s[127-32*c-8*k -: 8];
            m2[k] = xt(a[k]);
            m4[k] = xt(m2[k]);
            m8[k] = xt(m4[k]);
            m9[k] = m8[k] ^ a[k];
            mb[k] = m8[k] ^ m2[k] ^ a[k];
            md[k] = m8[k] ^ m4[k] ^ a[k];
            me[k] = m8[k] ^ m4[k] ^ m2[k];
         end
         o[127-32*c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
         o[119-32*c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
         o[111-32*c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
         o[103-32*c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
      return o;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/aes_key_sched.sv
`default_nettype none
module aes_key_sched (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata,
   output logic                    busy,
   output logic [1:0]              key_len,
   output logic [14:0][127:0]      round_keys
);

   logic [1:0]        key_len_ff;
   logic [63:0]       key_ff [4];
   logic              run_ff;
   logic [5:0]        cnt_ff;
   logic [2:0]        mod_ff;
   logic [7:0]        rcon_ff;
   logic [31:0]       win_ff [8];
   logic [127:0]      store_ff [15];

   logic [2:0]        nk_last;
   logic [5:0]        total_last;
   logic [31:0]       far_word;
   logic [31:0]       t_word;
   logic [31:0]       word_in;
   logic              below_nk;
   logic              cfg_hit;

   assign cfg_hit = csr_we && (csr_index <= aes_pkg::REG_KEY_LAST);

   // key length in words minus one and last word index
   always_comb begin
      case (key_len_ff)
         2'd0: begin
            nk_last    = 3'd3;
            total_last = 6'd43;
            far_word   = win_ff[3];
         end
         2'd1: begin
            nk_last    = 3'd5;
            total_last = 6'd51;
            far_word   = win_ff[5];
         end
         default: begin
            nk_last    = 3'd7;
            total_last = 6'd59;
            far_word   = win_ff[7];
         end
      endcase
   end

   // next expanded word
   always_comb begin
      below_nk = (cnt_ff <= {3'd0, nk_last});
      t_word   = win_ff[0];
      if (mod_ff == 3'd0) begin
         t_word = aes_pkg::sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon_ff, 24'd0};
      end else if (nk_last == 3'd7 && mod_ff == 3'd4) begin
         t_word = aes_pkg::sub_word(win_ff[0]);
      end
      if (below_nk) begin
         word_in = cnt_ff[0] ? key_ff[cnt_ff[2:1]][31:0] : key_ff[cnt_ff[2:1]][63:32];
      end else begin
         word_in = far_word ^ t_word;
      end
   end

   // control: restart on reset or on any register write
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= '0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         run_ff  <= 1'b1;
         cnt_ff  <= '0;
         mod_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (cfg_hit) begin
         if (csr_index == aes_pkg::REG_KEY_SIZE) begin
            key_len_ff <= csr_wdata[1:0];
         end else begin
            key_ff[2'(csr_index - 3'd1)] <= csr_wdata;
         end
         run_ff  <= 1'b1;
         cnt_ff  <= '0;
         mod_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         mod_ff <= (mod_ff == nk_last) ? 3'd0 : mod_ff + 3'd1;
         if (!below_nk && mod_ff == 3'd0) begin
            rcon_ff <= aes_pkg::xt(rcon_ff);
         end
         if (cnt_ff == total_last) begin
            run_ff <= 1'b0;
         end
      end
   end

   // word window and round-key registers, four words per round key
   always_ff @(posedge clock) begin
      if (run_ff && !cfg_hit && !reset) begin
         win_ff[0] <= word_in;
         for (int j = 1; j < 8; j++) win_ff[j] <= win_ff[j-1];
         store_ff[cnt_ff[5:2]][{~cnt_ff[1:0], 5'd0} +: 32] <= word_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 15; i++) round_keys[i] = store_ff[i];
   end

   assign busy    = run_ff;
   assign key_len = key_len_ff;

endmodule
`default_nettype wire

### hw/rtl/aes_round.sv
`default_nettype none
module aes_round (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire aes_pkg::stage_ctl_type in_ctl,
   input  wire logic [127:0]           in_state,
   input  wire logic [127:0]           enc_key,
   input  wire logic [127:0]           dec_key,
   input  wire logic                   enc_final,
   input  wire logic                   dec_mix,
   output aes_pkg::stage_ctl_type      out_ctl,
   output logic [127:0]                out_state
);

   aes_pkg::stage_ctl_type ctl_ff;
   logic [127:0]           state_ff;
   logic [127:0]           state_in;
   logic [127:0]           enc_t;
   logic [127:0]           dec_t;

   // one encrypt or decrypt round
   always_comb begin
      enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(in_state));
      if (!enc_final) enc_t = aes_pkg::mix_columns(enc_t);
      enc_t = enc_t ^ enc_key;
      dec_t = aes_pkg::inv_sub_bytes(aes_pkg::inv_shift_rows(in_state)) ^ dec_key;
      if (dec_mix) dec_t = aes_pkg::inv_mix_columns(dec_t);
      state_in = in_ctl.decrypt ? dec_t : enc_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_ctl   = ctl_ff;
   assign out_state = state_ff;

endmodule
`default_nettype wire

### hw/rtl/aes_block_cipher_top.sv
`default_nettype none
// AES-128/192/256 ECB encrypt and decrypt, one round per pipeline stage.
// A block is taken on start while busy is low, one block every cycle; its
// result passes the stage 0 register, the round stage registers and the
// output register and is on the result ports with rsp_strobe, in order,
// for exactly one cycle. There is no back-pressure:
// the receiver must take every strobe. After reset and after every write to
// a register the key schedule runs one word per cycle, holding busy high
// until the last word is written; write registers only with no block in flight.
module aes_block_cipher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_strobe,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   logic [1:0]              key_len;
   logic [14:0][127:0]      round_keys;
   logic [3:0]              nr;
   logic [127:0]            rk [15];

   aes_pkg::stage_ctl_type  ctl   [15];
   logic [127:0]            state [15];

   aes_pkg::stage_ctl_type  ctl0_ff;
   logic [127:0]            state0_ff;
   logic                    strobe_ff;
   logic [127:0]            result_ff;

   aes_key_sched u_key (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .busy       (busy),
      .key_len    (key_len),
      .round_keys (round_keys)
   );

   assign nr = aes_pkg::rounds_of(key_len);

   // round keys as 128-bit words
   always_comb begin
      for (int r = 0; r < 15; r++)
         rk[r] = round_keys[r];
   end

   // stage 0: initial key add
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else begin
         ctl0_ff.valid   <= start && !busy;
         ctl0_ff.decrypt <= req_action;
      end
   end

   always_ff @(posedge clock) begin
      state0_ff <= {req_block_high, req_block_low} ^ (req_action ? rk[nr] : rk[0]);
   end

   assign ctl[0]   = ctl0_ff;
   assign state[0] = state0_ff;

   // round stages
   for (genvar k = 1; k <= aes_pkg::NumRounds; k++) begin : g_round
      localparam int R10 = (k <= 10) ? 10 - k : 0;
      localparam int R12 = (k <= 12) ? 12 - k : 0;
      localparam int R14 = 14 - k;
      logic [127:0] dec_key;

      always_comb begin
         case (key_len)
            2'd0:    dec_key = rk[R10];
            2'd1:    dec_key = rk[R12];
            default: dec_key = rk[R14];
         endcase
      end

      aes_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl[k-1]),
         .in_state  (state[k-1]),
         .enc_key   (rk[k]),
         .dec_key   (dec_key),
         .enc_final (nr == 4'(k)),
         .dec_mix   (nr > 4'(k)),
         .out_ctl   (ctl[k]),
         .out_state (state[k])
      );
   end

   // output register taps the last round for the key size
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl[nr].valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= state[nr];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_high = result_ff[127:64];
   assign rsp_result_low  = result_ff[63:0];

endmodule
`default_nettype wire

### hw/rtl/aes_chk.sv
`default_nettype none
module aes_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic       csr_we,
   input wire logic [2:0] csr_index
);

   // key schedule runs after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // pipeline empties on reset
   a_no_strobe_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe right after reset");

   // any register write restarts the key schedule
   a_write_restarts: assert property (@(posedge clock)
      (csr_we && (csr_index <= aes_pkg::REG_KEY_LAST)) |=> busy)
      else $error("register write did not start key expansion");

endmodule

bind aes_block_cipher_top aes_chk u_aes_chk (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_we     (csr_we),
   .csr_index  (csr_index)
);
`default_nettype wire

### test/aes_block_cipher_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module aes_block_cipher_top_tb;

   localparam int RANDOM_BLOCKS = 900;
   localparam int DRAIN_CYCLES  = 40;

   // register indexes beyond the package's own names
   localparam logic [2:0] REG_KEY_0_7   = 3'd1;
   localparam logic [2:0] REG_KEY_8_15  = 3'd2;
   localparam logic [2:0] REG_KEY_16_23 = 3'd3;
   localparam logic [2:0] REG_KEY_24_31 = aes_pkg::REG_KEY_LAST;
   localparam logic [2:0] REG_NONE      = 3'd7;

   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [63:0] req_block_high;
   logic [63:0] req_block_low;
   logic        rsp_strobe;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   aes_block_cipher_top DUT (.*);

   // cipher state owned by the testbench
   logic [1:0]  ks_code;
   logic [63:0] key_reg [4];
   logic [31:0] rk_word [60];
   logic [7:0]  fwd_box [256];
   logic [7:0]  inv_box [256];

   typedef struct {
      logic [63:0] high;
      logic [63:0] low;
   } block_type;

   block_type expected_blocks[$];
   int        n_errors;
   int        n_blocks_out;
   int        n_enc;
   int        n_dec;
   int        idle_pct;

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_dbl(a);
      end
      return p;
   endfunction

   // S-box from the field inverse and the affine map
   task automatic build_boxes();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int i = 0; i < 254; i++) inv = gf_mul(inv, 8'(x));
         if (x == 0) inv = 8'h00;
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_box[x] = s;
      end
      for (int x = 0; x < 256; x++) inv_box[fwd_box[x]] = 8'(x);
   endtask

   function automatic int key_words();
      return (ks_code == 2'd0) ? 4 : (ks_code == 2'd1) ? 6 : 8;
   endfunction

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      int         nk, total;
      logic [7:0] rc;
      logic [31:0] t;
      nk = key_words();
      total = 4 * (nk + 7);
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         rk_word[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = rk_word[i - 1];
         if (i % nk == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gf_dbl(rc);
         end else if (nk == 8 && i % 8 == 4) begin
            t = subst_word(t);
         end
         rk_word[i] = rk_word[i - nk] ^ t;
      end
   endtask

   task automatic apply_reg(input logic [2:0] idx, input logic [63:0] val);
      if (idx == aes_pkg::REG_KEY_SIZE) ks_code = val[1:0];
      else if (idx <= aes_pkg::REG_KEY_LAST) key_reg[idx - 1] = val;
      else return;
      expand_schedule();
   endtask

   // state bytes s[0..15], byte 0 first
   typedef logic [7:0] state_type [16];

   function automatic void add_key(ref state_type s, input int rnd);
      logic [31:0] w;
      for (int c = 0; c < 4; c++) begin
         w = rk_word[4 * rnd + c];
         for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[31 - 8 * r -: 8];
      end
   endfunction

   function automatic void shift(ref state_type s, input bit inverse);
      state_type o;
      o = s;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            if (inverse) s[r + 4 * ((c + r) & 3)] = o[r + 4 * c];
            else         s[r + 4 * c] = o[r + 4 * ((c + r) & 3)];
   endfunction

   function automatic void mix(ref state_type s, input bit inverse);
      logic [7:0] m [4];
      logic [7:0] col [4];
      logic [7:0] v;
      if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else         m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = s[4 * c + k];
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mul(m[(k - r + 4) & 3], col[k]);
            s[4 * c + r] = v;
         end
      end
   endfunction

   function automatic block_type cipher_block(input logic act, input logic [63:0] hi,
                                              input logic [63:0] lo);
      state_type s;
      block_type b;
      int        nr;
      nr = key_words() + 6;
      for (int i = 0; i < 8; i++) begin
         s[i]     = hi[63 - 8 * i -: 8];
         s[8 + i] = lo[63 - 8 * i -: 8];
      end
      if (act == ACT_ENCRYPT) begin
         add_key(s, 0);
         for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int i = 0; i < 16; i++) s[i] = fwd_box[s[i]];
            shift(s, 1'b0);
            if (rnd != nr) mix(s, 1'b0);
            add_key(s, rnd);
         end
      end else begin
         add_key(s, nr);
         for (int rnd = nr - 1; rnd >= 0; rnd--) begin
            shift(s, 1'b1);
            for (int i = 0; i < 16; i++) s[i] = inv_box[s[i]];
            add_key(s, rnd);
            if (rnd > 0) mix(s, 1'b1);
         end
      end
      for (int i = 0; i < 8; i++) begin
         b.high[63 - 8 * i -: 8] = s[i];
         b.low[63 - 8 * i -: 8]  = s[8 + i];
      end
      return b;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   // result checker
   always @(posedge clock) begin
      block_type exp_b;
      if (!reset && rsp_strobe) begin
         n_blocks_out++;
         if (expected_blocks.size() == 0) begin
            $error("result with no block pending: %h %h", rsp_result_high, rsp_result_low);
            n_errors++;
         end else begin
            exp_b = expected_blocks.pop_front();
            if (rsp_result_high !== exp_b.high) begin
               $error("result_high expected %h actual %h", exp_b.high, rsp_result_high);
               n_errors++;
            end
            if (rsp_result_low !== exp_b.low) begin
               $error("result_low expected %h actual %h", exp_b.low, rsp_result_low);
               n_errors++;
            end
         end
      end
   end

   // one transfer; gap chosen from the idle percentage
   task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_block_high <= hi;
      req_block_low  <= lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      expected_blocks.push_back(cipher_block(act, hi, lo));
      if (act == ACT_ENCRYPT) n_enc++;
      else n_dec++;
   endtask

   // write enable stays high for back-to-back writes; the caller drops it
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_reg(idx, val);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      drain();
      write_reg(aes_pkg::REG_KEY_SIZE, {62'd0, ks});
      write_reg(REG_KEY_0_7, k0);
      write_reg(REG_KEY_8_15, k1);
      write_reg(REG_KEY_16_23, k2);
      write_reg(REG_KEY_24_31, k3);
      csr_we <= 1'b0;
   endtask

   typedef struct {
      logic        act;
      logic [63:0] hi;
      logic [63:0] lo;
      bit          known;
      logic [63:0] exp_hi;
      logic [63:0] exp_lo;
   } vector_type;

   // FIPS-197 appendix C plaintext and key bytes 00..1f
   localparam logic [63:0] PT_HI  = 64'h0011223344556677;
   localparam logic [63:0] PT_LO  = 64'h8899aabbccddeeff;
   localparam logic [63:0] KEY_A  = 64'h0001020304050607;
   localparam logic [63:0] KEY_B  = 64'h08090a0b0c0d0e0f;
   localparam logic [63:0] KEY_C  = 64'h1011121314151617;
   localparam logic [63:0] KEY_D  = 64'h18191a1b1c1d1e1f;

   task automatic run_vectors(input vector_type vt []);
      block_type b;
      foreach (vt[i]) begin
         if (vt[i].known) begin
            b = cipher_block(vt[i].act, vt[i].hi, vt[i].lo);
            if (b.high !== vt[i].exp_hi || b.low !== vt[i].exp_lo) begin
               $error("known vector %0d result expected %h%h actual %h%h", i,
                      vt[i].exp_hi, vt[i].exp_lo, b.high, b.low);
               n_errors++;
            end
         end
         send_block(vt[i].act, vt[i].hi, vt[i].lo);
      end
   endtask

   initial begin
      vector_type zero_key_rows [];
      vector_type k128_rows [];
      vector_type k192_rows [];
      vector_type k256_rows [];
      logic [63:0] k [4];
      logic [1:0]  ks;
      start = 1'b0; req_action = 1'b0; req_block_high = '0; req_block_low = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      n_errors = 0; n_blocks_out = 0; n_enc = 0; n_dec = 0; idle_pct = 0;
      ks_code = 2'd0;
      foreach (key_reg[i]) key_reg[i] = '0;
      build_boxes();
      expand_schedule();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // after reset: all-zero 128-bit key
      zero_key_rows = '{
         '{ACT_ENCRYPT, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
         '{ACT_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
         '{ACT_ENCRYPT, '1, '1, 1'b0, '0, '0},
         '{ACT_DECRYPT, '1, '1, 1'b0, '0, '0},
         '{ACT_DECRYPT, '0, '0, 1'b0, '0, '0}};
      run_vectors(zero_key_rows);

      load_key(2'd0, KEY_A, KEY_B, 64'hdeadbeefcafef00d, 64'h0123456789abcdef);
      k128_rows = '{
         '{ACT_ENCRYPT, PT_HI, PT_LO, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
         '{ACT_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, PT_HI, PT_LO},
         '{ACT_ENCRYPT, '1, '0, 1'b0, '0, '0}};
      run_vectors(k128_rows);

      load_key(2'd1, KEY_A, KEY_B, KEY_C, 64'hffffffffffffffff);
      k192_rows = '{
         '{ACT_ENCRYPT, PT_HI, PT_LO, 1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
         '{ACT_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1, PT_HI, PT_LO},
         '{ACT_DECRYPT, '0, '1, 1'b0, '0, '0}};
      run_vectors(k192_rows);

      load_key(2'd2, KEY_A, KEY_B, KEY_C, KEY_D);
      k256_rows = '{
         '{ACT_ENCRYPT, PT_HI, PT_LO, 1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
         '{ACT_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, PT_HI, PT_LO}};
      run_vectors(k256_rows);

      // unused size code acts as 256 bits; out-of-range index is ignored
      drain();
      write_reg(aes_pkg::REG_KEY_SIZE, 64'h3);
      write_reg(REG_NONE, '1);
      csr_we <= 1'b0;
      run_vectors(k256_rows);

      // random phases: key settings and idle levels vary per phase
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 64;
            2: idle_pct = 30;
            default: idle_pct = $urandom_range(10);
         endcase
         ks = 2'($urandom_range(3));
         for (int i = 0; i < 4; i++) begin
            case (ph)
               0: k[i] = '0;
               1: k[i] = '1;
               default: k[i] = {$urandom, $urandom};
            endcase
         end
         load_key(ks, k[0], k[1], k[2], k[3]);
         for (int n = 0; n < RANDOM_BLOCKS / 12; n++)
            send_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
      end

      drain();
      $display("Checked %0d cipher blocks (%0d encrypt, %0d decrypt) over 128/192/256-bit keys,",
               n_blocks_out, n_enc, n_dec);
      $display("with varying sender gaps and key changes between phases.");
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
